/* rtl/ccpb_pkg.sv */
package ccpb_pkg;

  localparam int unsigned PIXEL_W = 32;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam logic [PIXEL_W-1:0] ALPHA_MASK = 32'hff00_0000;
  localparam logic [PIXEL_W-1:0] RGB_MASK   = 32'h00ff_ffff;
  localparam logic [CHAN_W-1:0]  CHAN_MAX   = 8'hff;

  localparam logic [2:0] MODE_FILL_ARGB  = 3'd0;
  localparam logic [2:0] MODE_FILL_RGB   = 3'd1;
  localparam logic [2:0] MODE_FILL_ALPHA = 3'd2;
  localparam logic [2:0] MODE_BLEND      = 3'd3;
  localparam logic [2:0] MODE_ADDITIVE   = 3'd4;

  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_FILL_COLOR = 2'd1;
  localparam logic [1:0] REG_OPACITY    = 2'd2;
  localparam logic [1:0] REG_FILL_ALPHA = 2'd3;

  typedef struct packed {
    logic [PIXEL_W-1:0] dest_pixel;
    logic               end_of_run;
  } in_req_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] result_pixel;
    logic               run_done;
  } out_req_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [PIXEL_W-1:0] fill_color;
    logic [CHAN_W-1:0]  opacity;
    logic [CHAN_W-1:0]  fill_alpha;
  } ccpb_cfg_t;

endpackage

/* rtl/ccpb_datapath.sv */
module ccpb_datapath (
  input  ccpb_pkg::ccpb_cfg_t cfg,
  input  logic [31:0]         dest_pixel,
  output logic [31:0]         result_pixel
);
  import ccpb_pkg::*;

  logic [CHAN_W-1:0]  inv_opa;
  logic [CHAN_W:0]    add_a;
  logic [PIXEL_W-1:0] blend_px;
  logic [PIXEL_W-1:0] add_px;

  assign inv_opa = CHAN_MAX - cfg.opacity;
  assign add_a   = {1'b0, cfg.opacity} + {{CHAN_W{1'b0}}, cfg.opacity[CHAN_W-1]};

  assign blend_px[31:24] = dest_pixel[31:24];

  for (genvar k = 0; k < 3; k++) begin : g_blend
    logic [15:0] d_term;
    logic [15:0] c_term;
    logic [15:0] bsum;
    assign d_term = {8'd0, dest_pixel[8*k +: 8]} * {8'd0, inv_opa};
    assign c_term = {8'd0, cfg.fill_color[8*k +: 8]} * {8'd0, cfg.opacity};
    assign bsum   = d_term + c_term;
    assign blend_px[8*k +: 8] = bsum[15:8];
  end

  for (genvar k = 0; k < 4; k++) begin : g_add
    logic [16:0] x_prod;
    logic [16:0] c_prod;
    logic [8:0]  s_term;
    logic [9:0]  v;
    assign x_prod = {9'd0, dest_pixel[8*k +: 8]} * {8'd0, add_a};
    assign c_prod = {9'd0, cfg.fill_color[8*k +: 8]} * {8'd0, add_a};
    assign s_term = (k == 3) ? add_a : c_prod[16:8];
    assign v = {2'b00, dest_pixel[8*k +: 8]} - {1'b0, x_prod[16:8]} + {1'b0, s_term};
    assign add_px[8*k +: 8] = (v > 10'd255) ? CHAN_MAX : v[7:0];
  end

  always_comb begin
    case (cfg.mode)
      MODE_FILL_ARGB:  result_pixel = cfg.fill_color;
      MODE_FILL_RGB:   result_pixel = (dest_pixel & ALPHA_MASK) | (cfg.fill_color & RGB_MASK);
      MODE_FILL_ALPHA: result_pixel = (dest_pixel & RGB_MASK) | {cfg.fill_alpha, 24'd0};
      MODE_BLEND:      result_pixel = blend_px;
      MODE_ADDITIVE:   result_pixel = add_px;
      default:         result_pixel = dest_pixel;
    endcase
  end

endmodule

/* rtl/const_color_pixel_blend.sv */
// Constant-color ARGB8888 pixel processor: one destination pixel in, one processed pixel out,
// chosen by the mode register (fill ARGB, fill RGB, fill alpha, blend, additive blend). Takes a
// pixel every clock while in_stall is low; each pixel passes through the input register and then
// the result register, with all channel math done between them. Input stall rises only when the
// result register is full and stalled, and pixels are independent. Registers sit on the APB port
// at byte offsets 0x0 mode, 0x4 fill_color, 0x8 opacity, 0xC fill_alpha; write them only while
// no pixels are in flight.
module const_color_pixel_blend (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  ccpb_pkg::in_req_t       in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output ccpb_pkg::out_req_t      out_data,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [3:0]              cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  import ccpb_pkg::*;

  ccpb_cfg_t cfg_r, cfg_nxt;
  logic      cfg_we;
  logic [1:0] reg_idx;

  logic      s1_valid_r, s1_valid_nxt;
  in_req_t   s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  out_req_t  out_data_r;
  logic      out_adv;
  logic      s1_adv;
  logic [PIXEL_W-1:0] result_px;

  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx)
        REG_MODE:       cfg_nxt.mode       = cfg_pwdata[2:0];
        REG_FILL_COLOR: cfg_nxt.fill_color = cfg_pwdata;
        REG_OPACITY:    cfg_nxt.opacity    = cfg_pwdata[7:0];
        REG_FILL_ALPHA: cfg_nxt.fill_alpha = cfg_pwdata[7:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:       cfg_prdata = {29'd0, cfg_r.mode};
      REG_FILL_COLOR: cfg_prdata = cfg_r.fill_color;
      REG_OPACITY:    cfg_prdata = {24'd0, cfg_r.opacity};
      REG_FILL_ALPHA: cfg_prdata = {24'd0, cfg_r.fill_alpha};
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= MODE_FILL_ARGB;
      cfg_r.fill_color <= '0;
      cfg_r.opacity    <= CHAN_MAX;
      cfg_r.fill_alpha <= CHAN_MAX;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // advance the result register when empty or taken; the input register behind it
  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_stall = !s1_adv;

  assign s1_valid_nxt  = s1_adv ? in_valid : s1_valid_r;
  assign out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;

  ccpb_datapath u_dp (
    .cfg          (cfg_r),
    .dest_pixel   (s1_data_r.dest_pixel),
    .result_pixel (result_px)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_data_r <= in_data;
    end
    if (out_adv && s1_valid_r) begin
      out_data_r.result_pixel <= result_px;
      out_data_r.run_done     <= s1_data_r.end_of_run;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/ccpb_checker.sv */
module ccpb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ccpb_pkg::out_req_t out_data
);
  import ccpb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result request changed");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side free");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result request without matching input request");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> ##1 out_valid)
    else $error("accepted request did not reach the result register");

endmodule

bind const_color_pixel_blend ccpb_checker u_ccpb_checker (.*);
